[design/pwq_pkg.sv]
// Package with the types, widths and constants shared by the paced register write queue.
package pwq_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;

  localparam int ADDR_W    = 9;
  localparam int DATA_W    = 8;
  localparam int SPACING_W = 10;
  localparam int TIME_W    = 32;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 10'd2;
  localparam logic [SPACING_W-1:0] SPACING_MIN   = 10'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Low byte that keeps its bank-one bit when folding is applied.
  localparam logic [7:0] KEEP_BANK_LOW = 8'h05;

  // Command queue between the front and the back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] reg_addr;
    logic [DATA_W-1:0] reg_data;
    logic              extended_mode;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] out_addr;
    logic [DATA_W-1:0] out_data;
    logic              forced;
  } out_item_t;

  typedef struct packed {
    logic                 is_tick;
    logic [ADDR_W-1:0]    reg_addr;
    logic [DATA_W-1:0]    reg_data;
    logic                 extended_mode;
    logic [SPACING_W-1:0] gap;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } entry_t;

endpackage

[design/pwq_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module pwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/pwq_front.sv]
// Front end: accepts items, classifies them into commands and queues them for the back end.
module pwq_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  pwq_pkg::in_item_t              in_item,
  input  logic                           cfg_we,
  input  logic [pwq_pkg::SPACING_W-1:0]  cfg_data,
  output logic                           cmd_valid,
  output pwq_pkg::cmd_t                  cmd,
  input  logic                           cmd_pop
);

  logic [pwq_pkg::SPACING_W-1:0]  spacing_r;
  pwq_pkg::cmd_t                  q_r [pwq_pkg::CMDQ_DEPTH];
  logic [pwq_pkg::CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pwq_pkg::CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pwq_pkg::CMDQ_CNT_W-1:0] count_r, count_nxt;
  logic                           push;
  logic                           pop;
  pwq_pkg::cmd_t                  new_cmd;

  // The spacing is bound to each write when it is accepted, so a later
  // register write never changes a write that is still queued.
  always_comb begin
    new_cmd.is_tick       = (in_item.opcode == pwq_pkg::OP_TICK);
    new_cmd.reg_addr      = in_item.reg_addr;
    new_cmd.reg_data      = in_item.reg_data;
    new_cmd.extended_mode = in_item.extended_mode;
    new_cmd.gap           = (spacing_r == '0) ? pwq_pkg::SPACING_MIN : spacing_r;
  end

  assign busy      = (count_r == pwq_pkg::CMDQ_CNT_W'(pwq_pkg::CMDQ_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = start && !busy;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == pwq_pkg::CMDQ_PTR_W'(pwq_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + pwq_pkg::CMDQ_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == pwq_pkg::CMDQ_PTR_W'(pwq_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + pwq_pkg::CMDQ_PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + pwq_pkg::CMDQ_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - pwq_pkg::CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= pwq_pkg::SPACING_RESET;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      count_r   <= '0;
    end else begin
      if (cfg_we) begin
        spacing_r <= cfg_data;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

[design/pwq_back.sv]
// Back end: stamps writes, keeps the ring of pending writes and releases entries.
module pwq_back #(
  parameter int QUEUE_DEPTH = pwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  pwq_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               out_strobe,
  output pwq_pkg::out_item_t out_item
);

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                        state_r, state_nxt;
  pwq_pkg::cmd_t               cmd_r;
  logic [SLOT_W-1:0]           head_r, head_nxt;
  logic [SLOT_W-1:0]           tail_r, tail_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [pwq_pkg::TIME_W-1:0]  sample_time_r, sample_time_nxt;
  logic [pwq_pkg::TIME_W-1:0]  last_stamp_r, last_stamp_nxt;
  logic                        out_strobe_r, out_strobe_nxt;
  pwq_pkg::out_item_t          out_item_r, out_item_nxt;

  logic                        ram_we;
  pwq_pkg::entry_t             ram_wdata;
  pwq_pkg::entry_t             head_entry;
  logic [$bits(pwq_pkg::entry_t)-1:0] ram_rdata;

  logic                        full;
  logic                        empty;
  logic [pwq_pkg::TIME_W-1:0]  stamp_try;
  logic [pwq_pkg::TIME_W-1:0]  stamp_diff;
  logic [pwq_pkg::TIME_W-1:0]  stamp;
  logic [pwq_pkg::TIME_W-1:0]  due_diff;
  logic                        due;
  logic [pwq_pkg::ADDR_W-1:0]  rel_addr;
  logic [SLOT_W-1:0]           head_inc;
  logic [SLOT_W-1:0]           tail_inc;

  // The head slot is read every cycle; the data is valid in ST_EXEC.
  pwq_ram #(
    .WIDTH ($bits(pwq_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign head_entry = pwq_pkg::entry_t'(ram_rdata);
  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty      = (count_r == '0);
  assign head_inc   = (head_r == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + SLOT_W'(1);
  assign tail_inc   = (tail_r == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + SLOT_W'(1);

  always_comb begin
    stamp_try  = last_stamp_r + pwq_pkg::TIME_W'(cmd_r.gap);
    stamp_diff = stamp_try - sample_time_r;
    stamp      = stamp_diff[pwq_pkg::TIME_W-1] ? sample_time_r : stamp_try;
    due_diff   = head_entry.stamp - sample_time_r;
    due        = !empty && ((due_diff == '0) || due_diff[pwq_pkg::TIME_W-1]);
  end

  // Bank-one addresses fold to bank zero unless extended mode is on or the
  // low byte is the one register that stays in bank one.
  always_comb begin
    rel_addr = head_entry.addr;
    if (head_entry.addr[pwq_pkg::ADDR_W-1] && !cmd_r.extended_mode &&
        (head_entry.addr[7:0] != pwq_pkg::KEEP_BANK_LOW)) begin
      rel_addr = {1'b0, head_entry.addr[pwq_pkg::ADDR_W-2:0]};
    end
  end

  assign ram_wdata.stamp = stamp;
  assign ram_wdata.addr  = cmd_r.reg_addr;
  assign ram_wdata.data  = cmd_r.reg_data;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    sample_time_nxt = sample_time_r;
    last_stamp_nxt  = last_stamp_r;
    out_strobe_nxt  = 1'b0;
    out_item_nxt    = out_item_r;
    cmd_pop         = 1'b0;
    ram_we          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt             = ST_IDLE;
        out_item_nxt.out_addr = rel_addr;
        out_item_nxt.out_data = head_entry.data;
        if (cmd_r.is_tick) begin
          out_item_nxt.forced = 1'b0;
          sample_time_nxt     = sample_time_r + pwq_pkg::TIME_W'(1);
          if (due) begin
            out_strobe_nxt = 1'b1;
            head_nxt       = head_inc;
            count_nxt      = count_r - CNT_W'(1);
          end
        end else begin
          out_item_nxt.forced = 1'b1;
          ram_we              = 1'b1;
          tail_nxt            = tail_inc;
          last_stamp_nxt      = stamp;
          if (full) begin
            out_strobe_nxt = 1'b1;
            head_nxt       = head_inc;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      sample_time_r <= '0;
      last_stamp_r  <= '0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      count_r       <= count_nxt;
      sample_time_r <= sample_time_nxt;
      last_stamp_r  <= last_stamp_nxt;
      out_strobe_r  <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("ring occupancy above its depth");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r) == ST_EXEC)
    else $error("release without an executed command");

  a_forced_is_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_item_r.forced) |-> !$past(cmd_r.is_tick))
    else $error("forced release caused by a tick");

  a_ring_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && !cmd_r.is_tick && full) |=> full)
    else $error("forced release changed occupancy");
`endif

endmodule

[design/paced_register_write_queue_top.sv]
// Top level of the paced register write queue: front end, command queue, back end.
//
// The block paces register writes bound for a synthesizer chip. An item is
// transferred in on the rising edge where start is high and busy is low. An
// item with opcode 0 queues a register write, stamped for release no earlier
// than the last stamp plus the spacing and no earlier than the current sample
// time. An item with opcode 1 is one sample tick: it releases the oldest queued
// write if that write is due, then advances the sample time.
// A write that finds the ring full releases the oldest entry at once, marked
// forced. Every release is a one-cycle pulse on out_strobe with out_item; the
// receiver cannot stall and must take each transfer in the cycle it appears.
// The front end holds a two-entry command queue, so busy rises only when two
// items wait. The back end handles one item at a time: an idle state takes it
// and an execute state acts on it, as the ring memory read is registered. With
// the back end idle, an accepted item passes the command queue, the command
// register and the output registers before its result is on the outputs.
// cfg_we with cfg_data writes the spacing in sample ticks; zero acts as one.
// The spacing is bound to each write as it is accepted.
// Synchronous reset clears the time counters, the ring pointers and the
// command queue and sets the spacing to two; ring contents are not cleared.
module paced_register_write_queue_top #(
  parameter int QUEUE_DEPTH = pwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pwq_pkg::in_item_t             in_item,
  output logic                          out_strobe,
  output pwq_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [pwq_pkg::SPACING_W-1:0] cfg_data
);

  // Commands cross from the front end to the back end through this handshake.
  logic          cmd_valid;
  logic          cmd_pop;
  pwq_pkg::cmd_t cmd;

  pwq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // The back end owns the ring memory, the sample time and the release logic.
  pwq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench for the paced register write queue: directed and random transfers.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Ring size of the block as built here, and the cycles allowed for the block
  // to finish an item that releases nothing (an item passes the command queue,
  // the command register and the output registers, with two queued ahead of it).
  localparam int RING_DEPTH    = pwq_pkg::QUEUE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_GAP       = 12;

  // The scoreboard keeps its own copy of the pacing state: the sample clock, the
  // last stamp handed out, the ring of stamped writes and the spacing in force.
  // Each accepted transfer is run through that copy, and every release it
  // causes is queued as the next register write the chip should see.
  class release_scoreboard;
    logic [pwq_pkg::SPACING_W-1:0] spacing;
    logic [pwq_pkg::TIME_W-1:0]    now_ticks;
    logic [pwq_pkg::TIME_W-1:0]    last_stamp;
    pwq_pkg::entry_t               ring [RING_DEPTH];
    int unsigned                   head_pos;
    int unsigned                   tail_pos;
    pwq_pkg::out_item_t            release_q [$];
    int                            errors;

    function new();
      spacing    = pwq_pkg::SPACING_RESET;
      now_ticks  = '0;
      last_stamp = '0;
      head_pos   = 0;
      tail_pos   = 0;
      errors     = 0;
    endfunction

    function int pending();
      return release_q.size();
    endfunction

    // Positions run modulo twice the depth, so full and empty differ.
    function int unsigned fill();
      return (tail_pos + 2 * RING_DEPTH - head_pos) % (2 * RING_DEPTH);
    endfunction

    // Releases the head entry. A bank-one address is folded to bank zero
    // unless the second bank is active or the low byte is the one exception.
    function void pop_release(logic ext, logic forced_flag);
      pwq_pkg::entry_t    e;
      pwq_pkg::out_item_t r;
      e = ring[head_pos % RING_DEPTH];
      r.out_addr = e.addr;
      if (e.addr[8] && !ext && e.addr[7:0] != pwq_pkg::KEEP_BANK_LOW) begin
        r.out_addr = {1'b0, e.addr[7:0]};
      end
      r.out_data = e.data;
      r.forced   = forced_flag;
      release_q.push_back(r);
      head_pos = (head_pos + 1) % (2 * RING_DEPTH);
    endfunction

    function void note_input(pwq_pkg::in_item_t it);
      logic [pwq_pkg::SPACING_W-1:0] gap;
      logic [pwq_pkg::TIME_W-1:0]    due_at;
      logic [pwq_pkg::TIME_W-1:0]    diff;
      if (it.opcode == pwq_pkg::OP_WRITE) begin
        // A spacing of zero would let two stamps coincide, so it counts as one.
        gap    = (spacing == '0) ? pwq_pkg::SPACING_MIN : spacing;
        due_at = last_stamp + pwq_pkg::TIME_W'(gap);
        diff   = due_at - now_ticks;
        if (diff[pwq_pkg::TIME_W-1]) begin
          due_at = now_ticks;
        end
        if (fill() >= RING_DEPTH) begin
          pop_release(it.extended_mode, 1'b1);
        end
        ring[tail_pos % RING_DEPTH].stamp = due_at;
        ring[tail_pos % RING_DEPTH].addr  = it.reg_addr;
        ring[tail_pos % RING_DEPTH].data  = it.reg_data;
        tail_pos   = (tail_pos + 1) % (2 * RING_DEPTH);
        last_stamp = due_at;
      end else begin
        if (fill() != 0) begin
          diff = ring[head_pos % RING_DEPTH].stamp - now_ticks;
          if (diff == '0 || diff[pwq_pkg::TIME_W-1]) begin
            pop_release(it.extended_mode, 1'b0);
          end
        end
        now_ticks = now_ticks + 1;
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    task check_result(pwq_pkg::out_item_t got);
      pwq_pkg::out_item_t want;
      if (release_q.size() == 0) begin
        report_mismatch($sformatf("unexpected release addr=%h data=%h forced=%b",
                                  got.out_addr, got.out_data, got.forced));
      end else begin
        want = release_q.pop_front();
        if (got.out_addr !== want.out_addr || got.out_data !== want.out_data ||
            got.forced !== want.forced) begin
          report_mismatch($sformatf("got addr=%h data=%h forced=%b, want addr=%h data=%h forced=%b",
                                    got.out_addr, got.out_data, got.forced,
                                    want.out_addr, want.out_data, want.forced));
        end
      end
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  pwq_pkg::in_item_t             in_item;
  logic                          out_strobe;
  pwq_pkg::out_item_t            out_item;
  logic                          cfg_we;
  logic [pwq_pkg::SPACING_W-1:0] cfg_data;

  release_scoreboard sb;
  int                burst_left;

  paced_register_write_queue_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Results cannot be held off, so every strobe is checked on the edge that
  // ends its cycle. Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sb.check_result(out_item);
    end
  end

  // Sender idle time: mostly a random gap, bounded by MAX_GAP, per transfer, with
  // occasional back-to-back stretches so the command queue fills and busy rises.
  function int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 30);
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function pwq_pkg::in_item_t make_item(logic op, logic [pwq_pkg::ADDR_W-1:0] addr,
                                        logic [pwq_pkg::DATA_W-1:0] data, logic ext);
    pwq_pkg::in_item_t it;
    it.opcode        = op;
    it.reg_addr      = addr;
    it.reg_data      = data;
    it.extended_mode = ext;
    return it;
  endfunction

  // Random item: writes in the given share, with the bank-one exception
  // address drawn often enough to meet every folding case.
  function pwq_pkg::in_item_t random_item(int write_pct);
    logic [pwq_pkg::ADDR_W-1:0] addr;
    if ($urandom_range(0, 5) == 0) begin
      addr = {1'b1, pwq_pkg::KEEP_BANK_LOW};
    end else begin
      addr = pwq_pkg::ADDR_W'($urandom_range(0, (1 << pwq_pkg::ADDR_W) - 1));
    end
    return make_item(($urandom_range(0, 99) < write_pct) ? pwq_pkg::OP_WRITE : pwq_pkg::OP_TICK,
                     addr,
                     pwq_pkg::DATA_W'($urandom_range(0, (1 << pwq_pkg::DATA_W) - 1)),
                     logic'($urandom_range(0, 1)));
  endfunction

  // Called at a falling edge. Start stays high after the transfer so that a
  // zero gap keeps it high; a nonzero gap lowers it at the very next falling
  // edge, ahead of the rising edge that would take the item again.
  task automatic send_item(pwq_pkg::in_item_t it, int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted release has arrived, then
  // gives the block time to finish items that release nothing.
  task automatic wait_drained();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The spacing is only changed while the block is idle.
  task automatic write_spacing(logic [pwq_pkg::SPACING_W-1:0] value);
    wait_drained();
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.spacing = value;
  endtask

  task automatic run_phase(int n_items, int write_pct, bit pause_midway);
    for (int i = 0; i < n_items; i++) begin
      if (pause_midway && i == n_items / 2) begin
        wait_drained();
      end
      send_item(random_item(write_pct), next_gap());
    end
  endtask

  initial begin
    pwq_pkg::in_item_t directed_q [$];
    sb         = new();
    burst_left = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset spacing of two. The first tick finds the ring empty and carries
    // all-ones address and data, which a tick must ignore. Then writes at the
    // field extremes and at each folding case, drained by ticks whose
    // extended-mode bit varies, since the releasing item decides the folding.
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h1FF, 8'hFF, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_WRITE, 9'h000, 8'h00, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_WRITE, 9'h1FF, 8'hFF, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_WRITE, 9'h105, 8'h5A, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_WRITE, 9'h1AA, 8'h81, 1'b1));
    directed_q.push_back(make_item(pwq_pkg::OP_WRITE, 9'h0AA, 8'h7E, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h1FF, 8'hFF, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h000, 8'h00, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h155, 8'hAA, 1'b1));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h0AA, 8'h55, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h1FF, 8'h00, 1'b1));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h000, 8'hFF, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h100, 8'h01, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h000, 8'h00, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h105, 8'h05, 1'b1));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h000, 8'h00, 1'b0));
    foreach (directed_q[i]) send_item(directed_q[i], next_gap());
    directed_q.delete();

    // A spacing of zero must behave as one.
    write_spacing('0);
    directed_q.push_back(make_item(pwq_pkg::OP_WRITE, 9'h105, 8'h11, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_WRITE, 9'h1FF, 8'h00, 1'b1));
    directed_q.push_back(make_item(pwq_pkg::OP_WRITE, 9'h100, 8'hFF, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h000, 8'h00, 1'b1));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h1FF, 8'hFF, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h000, 8'h00, 1'b0));
    directed_q.push_back(make_item(pwq_pkg::OP_TICK,  9'h000, 8'h00, 1'b0));
    foreach (directed_q[i]) send_item(directed_q[i], next_gap());

    // Random phases. Zero spacing with an even mix, then a small random
    // spacing with more ticks and a full drain halfway, then spacing one.
    run_phase(250, 50, 1'b0);
    write_spacing(pwq_pkg::SPACING_W'($urandom_range(2, 9)));
    run_phase(250, 35, 1'b1);
    write_spacing(pwq_pkg::SPACING_W'(1));
    run_phase(100, 60, 1'b0);

    // Largest spacing with mostly writes: stamps run far ahead of the sample
    // clock, the ring fills, and every further write forces out the head.
    write_spacing({pwq_pkg::SPACING_W{1'b1}});
    run_phase(330, 92, 1'b0);

    wait_drained();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // A release that never arrives leaves the drain waiting; this ends the run.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
design/pwq_pkg.sv
design/pwq_ram.sv
design/pwq_front.sv
design/pwq_back.sv
design/paced_register_write_queue_top.sv
tb/tb.sv
